// File: hdl/rcdm_pkg.sv
// shared types and constants of the rc pulse differential drive mixer
package rcdm_pkg;

  // pulse width window and mapping points in microseconds
  localparam int LOW_LIMIT_US  = 900;
  localparam int HIGH_LIMIT_US = 2100;
  localparam int CENTRE_US     = 1500;
  localparam int BOTTOM_US     = 1000;
  localparam int FULL_DUTY     = 255;

  // floor(d * 255 / 500) == (d * RECIP_MULT) >> RECIP_SHIFT for d up to 1000
  localparam int RECIP_MULT  = 534774;
  localparam int RECIP_SHIFT = 20;

  // field widths
  localparam int WIDTH_BITS = 15;
  localparam int DIST_BITS  = 10;
  localparam int DUTY_BITS  = 8;
  localparam int TOUT_BITS  = 16;
  localparam int DZ_BITS    = 8;

  // register reset values
  localparam logic [TOUT_BITS-1:0] TIMEOUT_RESET  = 16'd300;
  localparam logic [DZ_BITS-1:0]   DEADZONE_RESET = 8'd20;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_TIMEOUT  = 1'b0,
    REG_DEADZONE = 1'b1
  } reg_idx_t;

  // input item kinds
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // signed channel command, range -765..305
  typedef logic signed [10:0] cmd_t;

  // one channel after width selection and mapping
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } chan_t;

  // motor duties, left forward in the lowest bits
  typedef struct packed {
    logic [DUTY_BITS-1:0] right_reverse;
    logic [DUTY_BITS-1:0] right_forward;
    logic [DUTY_BITS-1:0] left_reverse;
    logic [DUTY_BITS-1:0] left_forward;
  } duty_t;

endpackage

// File: hdl/rc_pulse_differential_drive_mixer_core.sv
// top level of the rc pulse differential drive mixer
//
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    tdata: four captures, tuser: op
// out_     out  out_tvalid/out_tready  tdata: four duties, tuser: failsafe
// cfg_     in   cfg_wr_en              cfg_index, cfg_wdata
//
// one item per cycle: an input register feeds the mapping and mixing logic,
// whose result lands in the output register.
// a tick item advances the millisecond counter and yields no transfer.
// the counter is updated as an item leaves the input register, so order holds.
// rst_n is synchronous; it clears both valid flags, the counter and the config registers.
// a stalled output blocks only samples; ticks still drain the input register.
module rc_pulse_differential_drive_mixer_core #(
  parameter int TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // ch1_first[14:0], ch1_second[29:15], ch2_first[44:30], ch2_second[59:45], zero pad
  input  logic [63:0] in_tdata,
  // op[0]
  input  logic        in_tuser,
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // left_forward[7:0], left_reverse[15:8], right_forward[23:16], right_reverse[31:24]
  output logic [31:0] out_tdata,
  // failsafe[0]
  output logic        out_tuser
);
  import rcdm_pkg::*;

  localparam int CMP_BITS = (TIMER_BITS > TOUT_BITS) ? TIMER_BITS : TOUT_BITS;

  // configuration registers
  logic [TOUT_BITS-1:0] timeout_r;
  logic [DZ_BITS-1:0]   deadzone_r;

  // input register
  logic                  s1_valid_r;
  logic                  s1_op_r;
  logic [WIDTH_BITS-1:0] s1_ch1_first_r;
  logic [WIDTH_BITS-1:0] s1_ch1_second_r;
  logic [WIDTH_BITS-1:0] s1_ch2_first_r;
  logic [WIDTH_BITS-1:0] s1_ch2_second_r;

  // millisecond counter
  logic [TIMER_BITS-1:0] cnt_r;
  logic [TIMER_BITS-1:0] cnt_nxt;

  // output register
  logic  out_valid_r;
  duty_t out_duty_r;
  logic  out_fs_r;

  logic  s1_adv;
  logic  in_xfer;
  chan_t thr_chan;
  chan_t str_chan;
  duty_t duty_c;
  duty_t duty_nxt;
  logic  both_valid;
  logic  over;
  logic  fs_nxt;

  // handshake: ticks never need the output slot
  assign s1_adv    = s1_valid_r && (!s1_op_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_xfer   = in_tvalid && in_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= TIMEOUT_RESET;
      deadzone_r <= DEADZONE_RESET;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TIMEOUT:  timeout_r  <= cfg_wdata[TOUT_BITS-1:0];
        REG_DEADZONE: deadzone_r <= cfg_wdata[DZ_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r         <= in_tuser;
      s1_ch1_first_r  <= in_tdata[14:0];
      s1_ch1_second_r <= in_tdata[29:15];
      s1_ch2_first_r  <= in_tdata[44:30];
      s1_ch2_second_r <= in_tdata[59:45];
    end
  end

  // per channel mapping
  rcdm_chan_cmd u_thr (
    .first    (s1_ch1_first_r),
    .second   (s1_ch1_second_r),
    .deadzone (deadzone_r),
    .chan     (thr_chan)
  );

  rcdm_chan_cmd u_str (
    .first    (s1_ch2_first_r),
    .second   (s1_ch2_second_r),
    .deadzone (deadzone_r),
    .chan     (str_chan)
  );

  rcdm_mix u_mix (
    .thr  (thr_chan.cmd),
    .str  (str_chan.cmd),
    .duty (duty_c)
  );

  // failsafe: a fully valid sample clears the counter before the check
  assign both_valid = thr_chan.valid && str_chan.valid;
  assign over       = CMP_BITS'(cnt_r) > CMP_BITS'(timeout_r);
  assign fs_nxt     = !both_valid && over;
  assign duty_nxt   = fs_nxt ? duty_t'('0) : duty_c;

  // saturating tick counter
  always_comb begin
    cnt_nxt = cnt_r;
    if (s1_adv) begin
      if (s1_op_r == OP_TICK) begin
        if (cnt_r != '1) begin
          cnt_nxt = cnt_r + TIMER_BITS'(1);
        end
      end else if (both_valid) begin
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_op_r == OP_SAMPLE) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_op_r == OP_SAMPLE) begin
      out_duty_r <= duty_nxt;
      out_fs_r   <= fs_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_duty_r;
  assign out_tuser  = out_fs_r;

  // failsafe results carry no drive
  a_fs_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 32'd0)
    else $error("failsafe result with nonzero duty");

  // a side never drives forward and reverse together
  a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:0] == 8'd0 || out_tdata[15:8] == 8'd0)
                && (out_tdata[23:16] == 8'd0 || out_tdata[31:24] == 8'd0))
    else $error("both directions driven on one side");

  // a tick below saturation bumps the counter by one
  a_tick_inc: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_op_r == OP_TICK && cnt_r != '1
      |=> cnt_r == TIMER_BITS'($past(cnt_r) + TIMER_BITS'(1)))
    else $error("tick did not advance the counter");

  // a sample leaving the input register always shows up at the output
  a_sample_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_op_r == OP_SAMPLE |=> out_tvalid)
    else $error("sample result lost");

endmodule

// File: hdl/rcdm_chan_cmd.sv
// width selection, linear mapping and deadzone for one rc channel
module rcdm_chan_cmd (
  input  logic [rcdm_pkg::WIDTH_BITS-1:0] first,
  input  logic [rcdm_pkg::WIDTH_BITS-1:0] second,
  input  logic [rcdm_pkg::DZ_BITS-1:0]    deadzone,
  output rcdm_pkg::chan_t                 chan
);
  import rcdm_pkg::*;

  localparam logic [WIDTH_BITS-1:0] W_LOW    = WIDTH_BITS'(LOW_LIMIT_US);
  localparam logic [WIDTH_BITS-1:0] W_HIGH   = WIDTH_BITS'(HIGH_LIMIT_US);
  localparam logic [WIDTH_BITS-1:0] W_CENTRE = WIDTH_BITS'(CENTRE_US);
  localparam logic [WIDTH_BITS-1:0] W_BOTTOM = WIDTH_BITS'(BOTTOM_US);
  localparam int PROD_BITS = DIST_BITS + RECIP_SHIFT;
  localparam cmd_t CMD_FULL = 11'(FULL_DUTY);

  logic [WIDTH_BITS-1:0] w;
  logic [DIST_BITS-1:0]  delta;
  logic [PROD_BITS-1:0]  prod;
  logic [DIST_BITS-1:0]  q;
  cmd_t                  q_s;
  cmd_t                  raw;
  cmd_t                  neg_raw;
  logic [DIST_BITS-1:0]  mag;

  // first capture inside the window wins, zero if neither is
  always_comb begin
    if (first > W_LOW && first < W_HIGH) begin
      w = first;
    end else if (second > W_LOW && second < W_HIGH) begin
      w = second;
    end else begin
      w = '0;
    end
  end

  // distance from the mapping origin, never negative
  always_comb begin
    if (w > W_CENTRE) begin
      delta = DIST_BITS'(w - W_CENTRE);
    end else if (w >= W_BOTTOM) begin
      delta = DIST_BITS'(w - W_BOTTOM);
    end else begin
      delta = DIST_BITS'(W_BOTTOM - w);
    end
  end

  // scale by 255/500 through a reciprocal multiply
  assign prod = PROD_BITS'(delta) * PROD_BITS'(RECIP_MULT);
  assign q    = prod[RECIP_SHIFT +: DIST_BITS];
  assign q_s  = cmd_t'({1'b0, q});

  // signed command around the centre; the scaled distance truncates toward zero
  always_comb begin
    if (w > W_CENTRE) begin
      raw = q_s;
    end else if (w == W_CENTRE) begin
      raw = '0;
    end else if (w >= W_BOTTOM) begin
      raw = q_s - CMD_FULL;
    end else begin
      raw = -q_s - CMD_FULL;
    end
  end

  // deadzone on the magnitude
  assign neg_raw = -raw;
  assign mag     = raw[10] ? neg_raw[DIST_BITS-1:0] : raw[DIST_BITS-1:0];

  assign chan.valid = (w != '0);
  assign chan.cmd   = (mag < {2'b00, deadzone}) ? cmd_t'(0) : raw;

endmodule

// File: hdl/rcdm_mix.sv
// arcade mixing, clamping and forward/reverse split
module rcdm_mix (
  input  rcdm_pkg::cmd_t  thr,
  input  rcdm_pkg::cmd_t  str,
  output rcdm_pkg::duty_t duty
);
  import rcdm_pkg::*;

  localparam logic signed [11:0] SUM_FULL = 12'(FULL_DUTY);

  logic signed [11:0] left_sum;
  logic signed [11:0] right_sum;

  // clamp to the full duty range and split by sign
  function automatic logic [2*DUTY_BITS-1:0] split(input logic signed [11:0] v);
    logic signed [11:0] c;
    logic signed [11:0] n;
    logic [DUTY_BITS-1:0] fwd;
    logic [DUTY_BITS-1:0] rev;
    if (v > SUM_FULL) begin
      c = SUM_FULL;
    end else if (v < -SUM_FULL) begin
      c = -SUM_FULL;
    end else begin
      c = v;
    end
    n   = -c;
    fwd = (c > 12'sd0) ? c[DUTY_BITS-1:0] : '0;
    rev = (c < 12'sd0) ? n[DUTY_BITS-1:0] : '0;
    return {rev, fwd};
  endfunction

  // left is throttle plus steering, right is throttle minus steering
  assign left_sum  = {thr[10], thr} + {str[10], str};
  assign right_sum = {thr[10], thr} - {str[10], str};

  assign {duty.left_reverse, duty.left_forward}   = split(left_sum);
  assign {duty.right_reverse, duty.right_forward} = split(right_sum);

endmodule

// File: dv/tb_top.sv
// self-checking testbench for the rc pulse differential drive mixer core
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rcdm_pkg::*;

  localparam int SPAN_US = 500;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // one input transfer: item kind plus two captures per channel
  typedef struct packed {
    logic                  op;
    logic [WIDTH_BITS-1:0] c1a;
    logic [WIDTH_BITS-1:0] c1b;
    logic [WIDTH_BITS-1:0] c2a;
    logic [WIDTH_BITS-1:0] c2b;
  } capture_item_t;

  // one output transfer
  typedef struct packed {
    logic  failsafe;
    duty_t duty;
  } mix_result_t;

  // predicts the duties of each sample and checks them in order
  class duty_scoreboard;
    int unsigned   timeout_ms;
    int unsigned   deadzone;
    logic [15:0]   ms_count;
    mix_result_t   pending[$];
    int            errors;
    int            samples;
    int            ticks;
    int            cuts;

    function new();
      timeout_ms = 32'(TIMEOUT_RESET);
      deadzone   = 32'(DEADZONE_RESET);
      ms_count   = '0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [15:0] value);
      if (idx == REG_TIMEOUT) begin
        timeout_ms = 32'(value);
      end else begin
        deadzone = 32'(value[DZ_BITS-1:0]);
      end
    endfunction

    // first capture inside the open window wins, else no width
    function int pick_width(logic [WIDTH_BITS-1:0] a, logic [WIDTH_BITS-1:0] b);
      if (a > LOW_LIMIT_US && a < HIGH_LIMIT_US) return int'(a);
      if (b > LOW_LIMIT_US && b < HIGH_LIMIT_US) return int'(b);
      return 0;
    endfunction

    // width to signed command, division truncates toward zero
    function int map_command(int w);
      int v;
      v = 0;
      if (w > CENTRE_US) begin
        v = (w - CENTRE_US) * FULL_DUTY / SPAN_US;
      end else if (w < CENTRE_US) begin
        v = (w - BOTTOM_US) * FULL_DUTY / SPAN_US - FULL_DUTY;
      end
      if ((v < 0 ? -v : v) < int'(deadzone)) v = 0;
      return v;
    endfunction

    function int clamp_duty(int v);
      if (v > FULL_DUTY) return FULL_DUTY;
      if (v < -FULL_DUTY) return -FULL_DUTY;
      return v;
    endfunction

    function void note_item(capture_item_t it);
      int          w1;
      int          w2;
      int          thr;
      int          str;
      int          lft;
      int          rgt;
      mix_result_t r;
      if (it.op == OP_TICK) begin
        ticks++;
        if (ms_count != COUNT_MAX) ms_count++;
        return;
      end
      samples++;
      w1 = pick_width(it.c1a, it.c1b);
      w2 = pick_width(it.c2a, it.c2b);
      if (w1 != 0 && w2 != 0) ms_count = '0;
      r = '0;
      if (ms_count > timeout_ms) begin
        r.failsafe = 1'b1;
        cuts++;
      end else begin
        thr = map_command(w1);
        str = map_command(w2);
        lft = clamp_duty(thr + str);
        rgt = clamp_duty(thr - str);
        r.duty.left_forward  = 8'(lft > 0 ? lft : 0);
        r.duty.left_reverse  = 8'(lft < 0 ? -lft : 0);
        r.duty.right_forward = 8'(rgt > 0 ? rgt : 0);
        r.duty.right_reverse = 8'(rgt < 0 ? -rgt : 0);
      end
      pending.push_back(r);
    endfunction

    function void compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [31:0] data, logic fs);
      mix_result_t exp_r;
      duty_t       got;
      got = data;
      if (pending.size() == 0) begin
        $display("%0t unexpected transfer: expected none actual duty %h failsafe %b",
                 $time, data, fs);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      compare_field("left_forward", int'(exp_r.duty.left_forward), int'(got.left_forward));
      compare_field("left_reverse", int'(exp_r.duty.left_reverse), int'(got.left_reverse));
      compare_field("right_forward", int'(exp_r.duty.right_forward),
                    int'(got.right_forward));
      compare_field("right_reverse", int'(exp_r.duty.right_reverse),
                    int'(got.right_reverse));
      compare_field("failsafe", int'(exp_r.failsafe), int'(fs));
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_wr_en  = 1'b0;
  logic [0:0]  cfg_index  = '0;
  logic [15:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  duty_scoreboard mixer_sb = new();
  int tx_idle_pct = 38;
  int rx_idle_pct = 72;
  int cfg_writes  = 0;

  rc_pulse_differential_drive_mixer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: check each transfer, stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) mixer_sb.check_result(out_tdata, out_tuser);
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // present one item, with random gaps, and hold it until the transfer
  task send_item(input capture_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= {4'b0, it.c2b, it.c2a, it.c1b, it.c1a};
    do @(posedge clk); while (!in_tready);
    mixer_sb.note_item(it);
  endtask

  task send_sample(input int a, input int b, input int c, input int d);
    capture_item_t it;
    it = {OP_SAMPLE, 15'(a), 15'(b), 15'(c), 15'(d)};
    send_item(it);
  endtask

  // tick with junk captures, which the block must ignore
  task send_tick();
    capture_item_t it;
    it.op  = OP_TICK;
    it.c1a = 15'($urandom);
    it.c1b = 15'($urandom);
    it.c2a = 15'($urandom);
    it.c2b = 15'($urandom);
    send_item(it);
  endtask

  // stop the stream and wait until every duty result has come back
  task drain();
    in_tvalid <= 1'b0;
    while (mixer_sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task set_config(input logic [15:0] timeout, input logic [7:0] dz);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_TIMEOUT;
    cfg_wdata <= timeout;
    @(posedge clk);
    cfg_index <= REG_DEADZONE;
    cfg_wdata <= {8'b0, dz};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mixer_sb.set_reg(REG_TIMEOUT, timeout);
    mixer_sb.set_reg(REG_DEADZONE, {8'b0, dz});
    cfg_writes += 2;
  endtask

  // capture value: mostly in the window, with edges, centre, gaps and noise
  function automatic int rand_capture();
    int edges[9] = '{899, 900, 901, 999, 1000, 2000, 2099, 2100, 2101};
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom_range(32767);
      2: return edges[$urandom_range(8)];
      3: return $urandom_range(CENTRE_US - 40, CENTRE_US + 40);
      default: return $urandom_range(LOW_LIMIT_US + 1, HIGH_LIMIT_US - 1);
    endcase
  endfunction

  // random mix of samples and bursts of ticks
  task run_random(input int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      if ($urandom_range(99) < 30) begin
        burst = $urandom_range(1, 12);
        repeat (burst) send_tick();
        left -= burst;
      end else begin
        send_sample(rand_capture(), rand_capture(), rand_capture(), rand_capture());
        left--;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: window edges, centre, missing widths, deadzone edge
    send_tick();
    send_sample(1500, 0, 1500, 0);
    send_sample(2099, 0, 1500, 0);
    send_sample(901, 0, 1500, 0);
    send_sample(900, 2100, 1500, 0);
    send_sample(0, 1800, 2100, 1200);
    send_sample(32767, 32767, 32767, 32767);
    send_sample(1000, 0, 2000, 0);
    send_sample(1520, 0, 1480, 0);
    send_sample(1540, 0, 1460, 0);
    send_sample(2000, 0, 1000, 0);
    send_sample(1900, 0, 0, 1100);
    send_sample(0, 0, 1700, 0);
    send_sample(1700, 0, 0, 0);
    send_sample(21845, 10922, 10922, 21845);
    send_sample(1499, 1501, 1501, 1499);

    // directed: timeout fires, then a valid sample clears it
    set_config(16'd3, 8'd20);
    send_sample(1600, 0, 1400, 0);
    repeat (4) send_tick();
    send_sample(0, 0, 1600, 0);
    send_sample(1600, 0, 1400, 0);
    set_config(16'd0, 8'd0);
    send_tick();
    send_sample(1700, 0, 0, 0);
    send_sample(1700, 0, 1300, 0);

    run_random(185);

    // receiver keeps up, sender is slow
    tx_idle_pct = 72;
    rx_idle_pct = 38;
    set_config(16'd65534, 8'd255);
    run_random(185);
    set_config(16'($urandom_range(1, 40)), 8'($urandom_range(255)));
    run_random(185);

    // full rate both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_config(16'd10, 8'd128);
    run_random(185);
    set_config(16'($urandom_range(0, 25)), 8'($urandom_range(255)));
    run_random(185);

    drain();
    $display("covered %0d samples and %0d ticks, %0d failsafe results, %0d register writes",
             mixer_sb.samples, mixer_sb.ticks, mixer_sb.cuts, cfg_writes);
    if (mixer_sb.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", mixer_sb.pending.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
